FILE: src/utf16_to_utf8_encoder_assert.svh
// Assertion macros shared by the transcoder modules.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef UTF16_TO_UTF8_ENCODER_ASSERT_SVH
`define UTF16_TO_UTF8_ENCODER_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define U16U8_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent that holds in the cycle after the antecedent.
`define U16U8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/u16u8_pkg.sv
// Shared types, constants and the UTF-8 encode function of the transcoder.
// No dependencies.
`default_nettype none

package u16u8_pkg;

  localparam int COUNT_BITS = 24;
  localparam int CW         = COUNT_BITS + 1;
  localparam int MAX_BYTES  = 6;
  localparam int NB_W       = 3;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = QPTR_W + 1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SRC = 2'd1;
  localparam logic [1:0] ST_TGT = 2'd2;

  localparam logic REG_LBF = 1'b0;
  localparam logic REG_CAP = 1'b1;

  localparam logic [5:0]  SURR_HI_TAG = 6'b110110;
  localparam logic [5:0]  SURR_LO_TAG = 6'b110111;
  localparam logic [20:0] PLANE1_BASE = 21'h10000;
  localparam logic [COUNT_BITS-1:0] CAP_RESET = '1;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;   // b[0] is the lead byte
  } enc_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [NB_W-1:0]           nbytes;
    logic                      done;
    logic [1:0]                status;
    logic [COUNT_BITS-1:0]     bytes_written;
    logic [COUNT_BITS-1:0]     units_consumed;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic enc_t enc_code(input logic [20:0] c);
    enc_t e;
    e.b = '0;
    if (c < 21'h80) begin
      e.n    = 3'd1;
      e.b[0] = c[7:0];
    end else if (c < 21'h800) begin
      e.n    = 3'd2;
      e.b[0] = {3'b110, c[10:6]};
      e.b[1] = {2'b10, c[5:0]};
    end else if (c < 21'h10000) begin
      e.n    = 3'd3;
      e.b[0] = {4'b1110, c[15:12]};
      e.b[1] = {2'b10, c[11:6]};
      e.b[2] = {2'b10, c[5:0]};
    end else begin
      e.n    = 3'd4;
      e.b[0] = {5'b11110, c[20:18]};
      e.b[1] = {2'b10, c[17:12]};
      e.b[2] = {2'b10, c[11:6]};
      e.b[3] = {2'b10, c[5:0]};
    end
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: src/u16u8_front.sv
// Front end: config registers, unit assembly, surrogate pairing, capacity check.
// Builds one queue record per item that has results. Uses u16u8_pkg.
`default_nettype none
`include "utf16_to_utf8_encoder_assert.svh"

module u16u8_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [15:0]                 in_tdata,    // [15:0] unit_bytes
  input  wire logic                        in_tlast,    // last_unit
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_addr,
  input  wire logic [u16u8_pkg::COUNT_BITS-1:0] cfg_wdata,
  input  wire u16u8_pkg::qstat_t           qstat,
  output logic                             push,
  output u16u8_pkg::item_t                 item
);

  logic                             lbf_r;
  logic [u16u8_pkg::COUNT_BITS-1:0] cap_r;
  logic [9:0]                       held_r, held_nxt;
  logic                             held_v_r, held_v_nxt;
  logic [u16u8_pkg::COUNT_BITS-1:0] bc_r, bc_nxt;
  logic [u16u8_pkg::COUNT_BITS-1:0] uc_r, uc_nxt;
  logic                             stopped_r, stopped_nxt;

  logic                             acc;
  logic [15:0]                      unit;
  logic                             u_high, u_low;
  u16u8_pkg::enc_t                  enc_pair, enc_flush, enc_unit;
  logic [u16u8_pkg::CW-1:0]         bc_ext, cap_ext, n_ext;
  logic                             fit_pair, fit_flush, fit_solo, fit_after;
  logic                             ok, flushed, st_valid;
  logic [1:0]                       st_code;
  logic [u16u8_pkg::NB_W-1:0]       nb;
  logic [u16u8_pkg::MAX_BYTES-1:0][7:0] bytes;
  logic [u16u8_pkg::COUNT_BITS-1:0] bc_rep, uc_rep;

  assign in_tready = !qstat.full;
  assign acc       = in_tvalid && in_tready;
  assign unit      = lbf_r ? {in_tdata[7:0], in_tdata[15:8]} : in_tdata;
  assign u_high    = (unit[15:10] == u16u8_pkg::SURR_HI_TAG);
  assign u_low     = (unit[15:10] == u16u8_pkg::SURR_LO_TAG);

  assign enc_pair  = u16u8_pkg::enc_code({1'b0, held_r, unit[9:0]} + u16u8_pkg::PLANE1_BASE);
  assign enc_flush = u16u8_pkg::enc_code({5'd0, u16u8_pkg::SURR_HI_TAG, held_r});
  assign enc_unit  = u16u8_pkg::enc_code({5'd0, unit});

  assign bc_ext    = {1'b0, bc_r};
  assign cap_ext   = {1'b0, cap_r};
  assign n_ext     = u16u8_pkg::CW'(enc_unit.n);
  assign fit_pair  = (bc_ext + u16u8_pkg::CW'(4)) <= cap_ext;
  assign fit_flush = (bc_ext + u16u8_pkg::CW'(3)) <= cap_ext;
  assign fit_solo  = (bc_ext + n_ext) <= cap_ext;
  assign fit_after = (bc_ext + u16u8_pkg::CW'(3) + n_ext) <= cap_ext;

  always_comb begin
    held_nxt    = held_r;
    held_v_nxt  = held_v_r;
    bc_nxt      = bc_r;
    uc_nxt      = uc_r;
    stopped_nxt = stopped_r;
    ok          = 1'b1;
    flushed     = 1'b0;
    st_valid    = 1'b0;
    st_code     = u16u8_pkg::ST_OK;
    nb          = '0;
    bytes       = '0;
    if (!stopped_r) begin
      if (held_v_r && u_low) begin
        if (fit_pair) begin
          bytes[3:0] = enc_pair.b;
          nb         = u16u8_pkg::NB_W'(4);
          bc_nxt     = bc_r + u16u8_pkg::COUNT_BITS'(4);
          uc_nxt     = uc_r + u16u8_pkg::COUNT_BITS'(2);
          held_v_nxt = 1'b0;
          st_valid   = in_tlast;
        end else begin
          st_valid = 1'b1;
          st_code  = u16u8_pkg::ST_TGT;
        end
      end else begin
        if (held_v_r) begin
          if (fit_flush) begin
            flushed    = 1'b1;
            bytes[2:0] = enc_flush.b[2:0];
            nb         = u16u8_pkg::NB_W'(3);
            bc_nxt     = bc_r + u16u8_pkg::COUNT_BITS'(3);
            uc_nxt     = uc_r + u16u8_pkg::COUNT_BITS'(1);
            held_v_nxt = 1'b0;
          end else begin
            ok       = 1'b0;
            st_valid = 1'b1;
            st_code  = u16u8_pkg::ST_TGT;
          end
        end
        if (ok) begin
          if (u_high) begin
            if (in_tlast) begin
              st_valid = 1'b1;
              st_code  = u16u8_pkg::ST_SRC;
            end else begin
              held_nxt   = unit[9:0];
              held_v_nxt = 1'b1;
            end
          end else if (flushed ? fit_after : fit_solo) begin
            if (flushed) begin
              bytes[5:3] = enc_unit.b[2:0];
            end else begin
              bytes[3:0] = enc_unit.b;
            end
            nb       = nb + enc_unit.n;
            bc_nxt   = bc_nxt + u16u8_pkg::COUNT_BITS'(enc_unit.n);
            uc_nxt   = uc_nxt + u16u8_pkg::COUNT_BITS'(1);
            st_valid = in_tlast;
          end else begin
            st_valid = 1'b1;
            st_code  = u16u8_pkg::ST_TGT;
          end
        end
      end
      if (st_valid && !in_tlast) begin
        stopped_nxt = 1'b1;
        held_v_nxt  = 1'b0;
      end
    end
    bc_rep = bc_nxt;
    uc_rep = uc_nxt;
    if (in_tlast) begin
      held_v_nxt  = 1'b0;
      bc_nxt      = '0;
      uc_nxt      = '0;
      stopped_nxt = 1'b0;
    end
  end

  assign push                = acc && !stopped_r && (st_valid || (nb != '0));
  assign item.bytes          = bytes;
  assign item.nbytes         = nb;
  assign item.done           = st_valid;
  assign item.status         = st_code;
  // counts as they stand after this item, before any end-of-string clear
  assign item.bytes_written  = bc_rep;
  assign item.units_consumed = uc_rep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lbf_r     <= 1'b0;
      cap_r     <= u16u8_pkg::CAP_RESET;
      held_r    <= '0;
      held_v_r  <= 1'b0;
      bc_r      <= '0;
      uc_r      <= '0;
      stopped_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          u16u8_pkg::REG_LBF: lbf_r <= cfg_wdata[0];
          u16u8_pkg::REG_CAP: cap_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (acc) begin
        held_r    <= held_nxt;
        held_v_r  <= held_v_nxt;
        bc_r      <= bc_nxt;
        uc_r      <= uc_nxt;
        stopped_r <= stopped_nxt;
      end
    end
  end

  `U16U8_ASSERT(a_stop_no_hold, !stopped_r || !held_v_r, "held unit kept after stop")
  `U16U8_ASSERT(a_stop_silent, !(acc && stopped_r) || !push, "record pushed while stopped")
  `U16U8_ASSERT(a_push_ready, !push || in_tready, "push into a full queue")

endmodule

`default_nettype wire

FILE: src/u16u8_queue.sv
// Four-entry record queue between the front end and the byte serializer.
// Uses u16u8_pkg.
`default_nettype none
`include "utf16_to_utf8_encoder_assert.svh"

module u16u8_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire u16u8_pkg::item_t wr_item,
  input  wire logic             pop,
  output u16u8_pkg::item_t      head,
  output u16u8_pkg::qstat_t     qstat
);

  u16u8_pkg::item_t                mem_r [u16u8_pkg::QDEPTH];
  logic [u16u8_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [u16u8_pkg::QCNT_W-1:0]    cnt_r;

  assign qstat.full  = (cnt_r == u16u8_pkg::QCNT_W'(u16u8_pkg::QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign head        = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `U16U8_ASSERT(a_pop_nonempty, !pop || !qstat.empty, "pop from empty queue")
  `U16U8_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "count lost a push")
  `U16U8_ASSERT(a_cnt_bound, cnt_r <= u16u8_pkg::QCNT_W'(u16u8_pkg::QDEPTH), "queue overfilled")

endmodule

`default_nettype wire

FILE: src/u16u8_back.sv
// Back end: walks the head record one beat per cycle, while out_tready allows, into the output register.
// Uses u16u8_pkg.
`default_nettype none
`include "utf16_to_utf8_encoder_assert.svh"

module u16u8_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire u16u8_pkg::qstat_t           qstat,
  input  wire u16u8_pkg::item_t            head,
  output logic                             pop,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [7:0]                       out_byte,
  output logic                             out_byte_valid,
  output logic                             out_end,
  output logic                             out_done,
  output logic [1:0]                       out_status,
  output logic [u16u8_pkg::COUNT_BITS-1:0] out_bytes_written,
  output logic [u16u8_pkg::COUNT_BITS-1:0] out_units_consumed
);

  logic                             out_tvalid_r;
  logic [u16u8_pkg::NB_W-1:0]       k_r;
  logic [7:0]                       byte_r;
  logic                             bval_r, last_r, done_r;
  logic [1:0]                       status_r;
  logic [u16u8_pkg::COUNT_BITS-1:0] bw_r, uc_r;

  logic [u16u8_pkg::NB_W-1:0]       beats_m1;
  logic                             load, is_end, has_byte, closing;

  assign beats_m1 = (head.nbytes == '0) ? '0 : head.nbytes - 1'b1;
  assign load     = !qstat.empty && (!out_tvalid_r || out_tready);
  assign is_end   = (k_r == beats_m1);
  assign has_byte = (k_r < head.nbytes);
  assign closing  = is_end && head.done;
  assign pop      = load && is_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      k_r          <= '0;
    end else if (load) begin
      out_tvalid_r <= 1'b1;
      k_r          <= is_end ? '0 : k_r + 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= has_byte ? head.bytes[k_r] : 8'd0;
      bval_r   <= has_byte;
      last_r   <= is_end;
      done_r   <= closing;
      status_r <= closing ? head.status : u16u8_pkg::ST_OK;
      bw_r     <= closing ? head.bytes_written : '0;
      uc_r     <= closing ? head.units_consumed : '0;
    end
  end

  assign out_tvalid         = out_tvalid_r;
  assign out_byte           = byte_r;
  assign out_byte_valid     = bval_r;
  assign out_end            = last_r;
  assign out_done           = done_r;
  assign out_status         = status_r;
  assign out_bytes_written  = bw_r;
  assign out_units_consumed = uc_r;

  `U16U8_ASSERT(a_mid_record, (k_r == '0) || !qstat.empty, "record left mid-walk")
  `U16U8_ASSERT(a_done_on_end, !(out_tvalid_r && done_r) || last_r, "close not on last beat")

endmodule

`default_nettype wire

FILE: src/utf16_to_utf8_encoder.sv
// UTF-16 to UTF-8 transcoder top level: front end, record queue, serializer.
// Uses u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back.
//
// Channel  Dir  Beat
// in_      in   one UTF-16 unit (tdata[15:0]), tlast marks the last unit of a string
// out_     out  one UTF-8 byte or a status-only beat, tlast ends one unit's results
// cfg_     in   register write: index 0 byte order, index 1 destination capacity
//
// The front end takes one unit per cycle while the 4-entry queue has room.
// The serializer sends one beat per cycle while out_tready allows: a record gives one beat
// per byte (up to 6 bytes) or one status-only beat, units with no result give none.
// Reset is synchronous, active low; it clears control state and sets capacity to all ones.
// The output register lets the queue keep filling while out_tready is low.
`default_nettype none

module utf16_to_utf8_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] unit_bytes
  input  wire logic        in_tlast,   // last_unit
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [7:0] out_byte, [9:8] status,
                                       // [33:10] bytes_written, [57:34] units_consumed
  output logic [1:0]       out_tuser,  // [0] byte_valid, [1] string_done
  output logic             out_tlast,  // end_of_run
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [23:0] cfg_wdata
);

  u16u8_pkg::qstat_t                qstat;
  u16u8_pkg::item_t                 wr_item, head;
  logic                             push, pop;
  logic [7:0]                       o_byte;
  logic                             o_bval, o_done;
  logic [1:0]                       o_status;
  logic [u16u8_pkg::COUNT_BITS-1:0] o_bw, o_uc;

  u16u8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .qstat     (qstat),
    .push      (push),
    .item      (wr_item)
  );

  u16u8_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .head    (head),
    .qstat   (qstat)
  );

  u16u8_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .qstat              (qstat),
    .head               (head),
    .pop                (pop),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_byte           (o_byte),
    .out_byte_valid     (o_bval),
    .out_end            (out_tlast),
    .out_done           (o_done),
    .out_status         (o_status),
    .out_bytes_written  (o_bw),
    .out_units_consumed (o_uc)
  );

  assign out_tdata = {6'd0, o_uc, o_bw, o_status, o_byte};
  assign out_tuser = {o_done, o_bval};

endmodule

`default_nettype wire

FILE: sim/u16u8_stream_monitor.sv
`timescale 1ns / 100ps
// Stream monitor for the UTF-16 to UTF-8 transcoder: watches the cfg_, in_ and out_
// ports, predicts the UTF-8 beats of every accepted unit and compares them in order.
// Depends on u16u8_pkg for status codes, register indexes and counter width.

module u16u8_stream_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [23:0] cfg_wdata,
  output int          mismatches,
  output int          beats_pending
);

  typedef struct packed {
    logic [7:0]                       data;
    logic                             has_data;
    logic                             run_end;
    logic                             done;
    logic [1:0]                       status;
    logic [u16u8_pkg::COUNT_BITS-1:0] nbytes;
    logic [u16u8_pkg::COUNT_BITS-1:0] nunits;
  } utf8_beat_t;

  utf8_beat_t utf8_beats_due[$];
  logic [7:0] seq_bytes[$];

  logic                             lbf;
  logic [23:0]                      cap;
  logic [15:0]                      held_unit;
  logic                             holding;
  logic [u16u8_pkg::COUNT_BITS-1:0] byte_cnt;
  logic [u16u8_pkg::COUNT_BITS-1:0] unit_cnt;
  logic                             halted;

  initial begin
    mismatches    = 0;
    beats_pending = 0;
  end

  function automatic bit is_high(input logic [15:0] u);
    return u >= 16'hD800 && u <= 16'hDBFF;
  endfunction

  function automatic bit is_low(input logic [15:0] u);
    return u >= 16'hDC00 && u <= 16'hDFFF;
  endfunction

  function automatic void clear_string();
    held_unit = '0;
    holding   = 1'b0;
    byte_cnt  = '0;
    unit_cnt  = '0;
    halted    = 1'b0;
  endfunction

  // Appends the UTF-8 sequence of cp if it fits in what is left of the capacity.
  function automatic bit append_utf8(input logic [20:0] cp);
    logic [2:0] n;
    if (cp < 21'h80) n = 3'd1;
    else if (cp < 21'h800) n = 3'd2;
    else if (cp < 21'h10000) n = 3'd3;
    else n = 3'd4;
    if ({8'd0, byte_cnt} + 32'(n) > {8'd0, cap}) return 1'b0;
    case (n)
      3'd1: seq_bytes.push_back(cp[7:0]);
      3'd2: begin
        seq_bytes.push_back({3'b110, cp[10:6]});
        seq_bytes.push_back({2'b10, cp[5:0]});
      end
      3'd3: begin
        seq_bytes.push_back({4'b1110, cp[15:12]});
        seq_bytes.push_back({2'b10, cp[11:6]});
        seq_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        seq_bytes.push_back({5'b11110, cp[20:18]});
        seq_bytes.push_back({2'b10, cp[17:12]});
        seq_bytes.push_back({2'b10, cp[11:6]});
        seq_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
    byte_cnt = byte_cnt + u16u8_pkg::COUNT_BITS'(n);
    return 1'b1;
  endfunction

  function automatic void transcode_unit(input logic [15:0] raw, input logic last);
    logic [15:0]                      u;
    logic                             closing;
    logic                             ok;
    logic [1:0]                       st;
    logic [u16u8_pkg::COUNT_BITS-1:0] rep_bytes;
    logic [u16u8_pkg::COUNT_BITS-1:0] rep_units;
    utf8_beat_t                       b;
    int                               nbeats;
    u         = lbf ? {raw[7:0], raw[15:8]} : raw;
    closing   = 1'b0;
    st        = u16u8_pkg::ST_OK;
    rep_bytes = '0;
    rep_units = '0;
    seq_bytes.delete();
    if (halted) begin
      if (last) clear_string();
      return;
    end
    if (holding && is_low(u)) begin
      if (append_utf8({1'b0, held_unit[9:0], u[9:0]} + 21'h10000)) begin
        unit_cnt  = unit_cnt + u16u8_pkg::COUNT_BITS'(2);
        holding   = 1'b0;
        held_unit = '0;
        if (last) closing = 1'b1;
      end else begin
        closing = 1'b1;
        st      = u16u8_pkg::ST_TGT;
      end
    end else begin
      ok = 1'b1;
      if (holding) begin
        if (append_utf8({5'd0, held_unit})) begin
          unit_cnt  = unit_cnt + u16u8_pkg::COUNT_BITS'(1);
          holding   = 1'b0;
          held_unit = '0;
        end else begin
          closing = 1'b1;
          st      = u16u8_pkg::ST_TGT;
          ok      = 1'b0;
        end
      end
      if (ok) begin
        if (is_high(u)) begin
          if (last) begin
            closing = 1'b1;
            st      = u16u8_pkg::ST_SRC;
          end else begin
            held_unit = u;
            holding   = 1'b1;
          end
        end else if (append_utf8({5'd0, u})) begin
          unit_cnt = unit_cnt + u16u8_pkg::COUNT_BITS'(1);
          if (last) closing = 1'b1;
        end else begin
          closing = 1'b1;
          st      = u16u8_pkg::ST_TGT;
        end
      end
    end
    if (closing) begin
      rep_bytes = byte_cnt;
      rep_units = unit_cnt;
      if (last) begin
        clear_string();
      end else begin
        halted    = 1'b1;
        holding   = 1'b0;
        held_unit = '0;
      end
    end else if (last) begin
      clear_string();
    end
    nbeats = seq_bytes.size();
    if (closing && nbeats == 0) nbeats = 1;
    for (int k = 0; k < nbeats; k++) begin
      b          = '0;
      b.has_data = k < seq_bytes.size();
      b.data     = b.has_data ? seq_bytes[k] : 8'h00;
      b.run_end  = k == nbeats - 1;
      if (b.run_end && closing) begin
        b.done   = 1'b1;
        b.status = st;
        b.nbytes = rep_bytes;
        b.nunits = rep_units;
      end
      utf8_beats_due.push_back(b);
    end
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    utf8_beat_t want;
    if (!rst_n) begin
      lbf = 1'b0;
      cap = u16u8_pkg::CAP_RESET;
      clear_string();
      utf8_beats_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          u16u8_pkg::REG_LBF: lbf = cfg_wdata[0];
          u16u8_pkg::REG_CAP: cap = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) transcode_unit(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (utf8_beats_due.size() == 0) begin
          report("beat with none due, byte", 32'd0, {24'd0, out_tdata[7:0]});
        end else begin
          want = utf8_beats_due.pop_front();
          if (out_tdata[7:0] !== want.data)
            report("out_byte", 32'(want.data), 32'(out_tdata[7:0]));
          if (out_tuser[0] !== want.has_data)
            report("byte_valid", 32'(want.has_data), 32'(out_tuser[0]));
          if (out_tlast !== want.run_end)
            report("end_of_run", 32'(want.run_end), 32'(out_tlast));
          if (out_tuser[1] !== want.done)
            report("string_done", 32'(want.done), 32'(out_tuser[1]));
          if (out_tdata[9:8] !== want.status)
            report("status", 32'(want.status), 32'(out_tdata[9:8]));
          if (out_tdata[33:10] !== want.nbytes)
            report("bytes_written", 32'(want.nbytes), 32'(out_tdata[33:10]));
          if (out_tdata[57:34] !== want.nunits)
            report("units_consumed", 32'(want.nunits), 32'(out_tdata[57:34]));
        end
      end
    end
    beats_pending <= utf8_beats_due.size();
  end

endmodule

FILE: sim/tb_utf16_to_utf8_encoder.sv
`timescale 1ns / 100ps
// Top of the transcoder testbench: clock, reset, register writes, UTF-16 unit
// stimulus, output stalls and the verdict. Needs u16u8_pkg, utf16_to_utf8_encoder
// and u16u8_stream_monitor.

module tb_utf16_to_utf8_encoder;

  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEM_TARGET = 310;
  localparam int SETTLE      = 20;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;    // [15:0] unit_bytes
  logic        in_tlast   = 1'b0;  // last_unit
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;          // [7:0] out_byte, [9:8] status,
                                   // [33:10] bytes_written, [57:34] units_consumed
  logic [1:0]  out_tuser;          // [0] byte_valid, [1] string_done
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = 1'b0;
  logic [23:0] cfg_wdata  = '0;

  int   mismatches;
  int   beats_pending;
  int   cycles     = 0;
  int   units_sent = 0;
  logic quiet      = 1'b0;
  logic cur_lbf    = 1'b0;
  int   rx_left    = 0;

  always #5 clk = ~clk;

  utf16_to_utf8_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  u16u8_stream_monitor chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .beats_pending (beats_pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // output stalls: random bursts with out_tready low between random runs with it high
  always @(posedge clk) begin
    if (quiet) begin
      out_tready <= 1'b1;
    end else if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else if (out_tready && $urandom_range(0, 1) == 0) begin
      out_tready <= 1'b0;
      rx_left    <= $urandom_range(0, 8);
    end else begin
      out_tready <= 1'b1;
      rx_left    <= $urandom_range(0, 19);
    end
  end

  task automatic send_unit(input logic [15:0] u, input logic last);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cur_lbf ? {u[7:0], u[15:8]} : u;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    units_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic lbf, input logic [23:0] cap);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= u16u8_pkg::REG_LBF;
    cfg_wdata <= {23'd0, lbf};
    @(posedge clk);
    cfg_addr  <= u16u8_pkg::REG_CAP;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_lbf = lbf;
  endtask

  task automatic send_code(input logic [20:0] cp, input logic last);
    logic [20:0] off;
    if (cp >= u16u8_pkg::PLANE1_BASE) begin
      off = cp - u16u8_pkg::PLANE1_BASE;
      send_unit({u16u8_pkg::SURR_HI_TAG, off[19:10]}, 1'b0);
      send_unit({u16u8_pkg::SURR_LO_TAG, off[9:0]}, last);
    end else begin
      send_unit(cp[15:0], last);
    end
  endtask

  function automatic logic [20:0] pick_code();
    int unsigned r;
    case ($urandom_range(0, 4))
      0: r = $urandom_range(0, 'h7F);
      1: r = $urandom_range('h80, 'h7FF);
      2: begin
        r = $urandom_range('h800, 'hF7FF);
        if (r >= 'hD800) r = r + 'h800;
      end
      default: r = $urandom_range('h10000, 'h10FFFF);
    endcase
    return r[20:0];
  endfunction

  function automatic logic [15:0] pick_noise();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range('hD800, 'hDBFF));
      1: return 16'($urandom_range('hDC00, 'hDFFF));
      default: return 16'($urandom());
    endcase
  endfunction

  // mostly well-formed strings; the rest random raw units, many of them surrogates
  task automatic send_random_string();
    int len;
    bit clean;
    len   = $urandom_range(1, 6);
    clean = $urandom_range(0, 3) != 0;
    for (int i = 0; i < len; i++) begin
      if (clean) send_code(pick_code(), i == len - 1);
      else send_unit(pick_noise(), i == len - 1);
    end
  endtask

  task automatic random_config();
    logic [23:0] cap;
    case ($urandom_range(0, 3))
      0: cap = 24'hFFFFFF;
      1: cap = 24'($urandom_range(0, 12));
      2: cap = 24'($urandom_range(13, 40));
      default: cap = 24'($urandom());
    endcase
    set_config(1'($urandom_range(0, 1)), cap);
  endtask

  initial begin
    int phase_end;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(1'b0, 24'hFFFFFF);
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'hDC00, 1'b0);   // lone low surrogate
    send_unit(16'hD800, 1'b0);
    send_unit(16'hFFFF, 1'b0);   // held high flushed, then 3 more bytes
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hD800, 1'b1);   // flush, then high as last unit
    send_unit(16'hD83D, 1'b1);   // high alone as last: status-only beat
    send_unit(16'h0041, 1'b1);

    set_config(1'b1, 24'h000000);
    send_unit(16'h0041, 1'b0);   // nothing fits: stop
    send_unit(16'h1234, 1'b0);
    send_unit(16'hABCD, 1'b1);

    set_config(1'b1, 24'd5);
    send_unit(16'h00E9, 1'b0);
    send_unit(16'hD83D, 1'b0);
    send_unit(16'hDE00, 1'b0);   // pair does not fit
    send_unit(16'h0041, 1'b1);

    set_config(1'b0, 24'd3);
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0041, 1'b1);   // flush fits, the new unit does not

    while (units_sent < ITEM_TARGET) begin
      random_config();
      if (units_sent >= ITEM_TARGET - 50) quiet <= 1'b1;
      phase_end = units_sent + 30;
      while (units_sent < phase_end) send_random_string();
    end

    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
